// ===== sv/all_pairs_shortest_path_relax_macros.svh =====
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_relax_macros
// Assertion helpers used by the RTL of the shortest path block.
// ----------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_RELAX_MACROS_SVH
`define ALL_PAIRS_SHORTEST_PATH_RELAX_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define APSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define APSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/apsp_pkg.sv =====
// ----------------------------------------------------------------------------
// apsp_pkg
// Request and response types and fixed codes of the shortest path block.
// ----------------------------------------------------------------------------
package apsp_pkg;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] STATUS_CONVERGED = 2'd0;
   localparam logic [1:0] STATUS_TOLERANCE = 2'd1;
   localparam logic [1:0] STATUS_LIMIT     = 2'd2;

   localparam logic KIND_RUN  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE    = 1'd1;

   localparam int PASS_CAP = 1023;

   typedef struct packed {
      logic [1:0]  command;
      logic [4:0]  row;
      logic [4:0]  col;
      logic        edge_present;
      logic [31:0] edge_length;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] distance;
      logic        distance_finite;
      logic [1:0]  run_status;
      logic [9:0]  pass_count;
   } rsp_type;

endpackage

// ===== sv/apsp_req_if.sv =====
// ----------------------------------------------------------------------------
// apsp_req_if
// Request channel: valid, ready and one request payload.
// ----------------------------------------------------------------------------
interface apsp_req_if;
   logic             valid;
   logic             ready;
   apsp_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/apsp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// apsp_rsp_if
// Response channel: valid, ready and one response payload.
// ----------------------------------------------------------------------------
interface apsp_rsp_if;
   logic             valid;
   logic             ready;
   apsp_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/apsp_ram.sv =====
// ----------------------------------------------------------------------------
// apsp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module apsp_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/all_pairs_shortest_path_relax.sv =====
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_relax
// All-pairs shortest path by repeated in-place relaxation over an edge matrix.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_chan. A write request loads one edge entry and gives
// no response. A read request holds req_chan.ready low until its response
// has been loaded into the output register that drives rsp_chan.
// A run request rebuilds the distance store from the edge store and relaxes
// it pass after pass; its response carries the stop status and pass count.
// A run first copies the edge store into the distance store, entry by entry.
// Each pass then walks every (i,k) pair with k != i; for a pair with a usable
// edge it reads D(k,j) and D(i,j) for each j other than i and k, and an
// improving update writes D(i,j) and then its mirror D(j,i). Only one request
// is worked on at a time.
// After reset the edge store is cleared by a sweep over all MAX_VERTICES^2
// entries, during which req_chan.ready stays low. The csr port may be
// written at any time the block is idle, including during the sweep.
// The response sits in an output register. While the receiver stalls, the
// block still takes write requests; a read or run finishes its work and
// then holds until the register frees up.
// ----------------------------------------------------------------------------
`include "all_pairs_shortest_path_relax_macros.svh"

module all_pairs_shortest_path_relax #(
   parameter int MAX_VERTICES = 32,
   parameter int LENGTH_BITS  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [apsp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata,
   apsp_req_if.sink                         req_chan,
   apsp_rsp_if.source                       rsp_chan
);
   localparam int IdxW      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CellCount = MAX_VERTICES * MAX_VERTICES;
   localparam int AddrW     = $clog2(CellCount);
   localparam int EntryW    = LENGTH_BITS + 1;
   localparam int EtW       = $clog2(CellCount + 1);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_READ     = 4'd2;
   localparam logic [3:0] S_INIT_RD  = 4'd3;
   localparam logic [3:0] S_INIT_WR  = 4'd4;
   localparam logic [3:0] S_SETUP    = 4'd5;
   localparam logic [3:0] S_K_RD     = 4'd6;
   localparam logic [3:0] S_K_CHK    = 4'd7;
   localparam logic [3:0] S_J_RD1    = 4'd8;
   localparam logic [3:0] S_J_RD2    = 4'd9;
   localparam logic [3:0] S_J_CMP    = 4'd10;
   localparam logic [3:0] S_J_WR2    = 4'd11;
   localparam logic [3:0] S_PASS_END = 4'd12;
   localparam logic [3:0] S_EMIT_RUN = 4'd13;

   function automatic logic [AddrW-1:0] cell_addr(input logic [IdxW-1:0] r,
                                                  input logic [IdxW-1:0] c);
      cell_addr = AddrW'(int'(r) * MAX_VERTICES + int'(c));
   endfunction

   // Control and loop state.
   logic [3:0]             state_ff, state_in;
   logic [AddrW-1:0]       clr_ff, clr_in;
   logic [IdxW-1:0]        i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IdxW:0]          n_ff, n_in;
   logic [EtW-1:0]         et_ff, et_in;
   logic [9:0]             limit_ff, limit_in, pass_ff, pass_in;
   logic                   changed_ff, changed_in;
   logic [1:0]             status_ff, status_in;
   logic                   rd_inrange_ff, rd_inrange_in;
   logic [5:0]             vc_ff, vc_in;
   logic [31:0]            tol_ff, tol_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [LENGTH_BITS-1:0] maxdiff_ff, maxdiff_in;
   logic [LENGTH_BITS-1:0] diff_ff, diff_in;
   logic [LENGTH_BITS-1:0] dik_ff, dik_in;
   logic [LENGTH_BITS-1:0] sum_ff, sum_in;
   logic                   kj_ok_ff, kj_ok_in;
   apsp_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic                   edge_we, edge_re, dist_we, dist_re;
   logic [AddrW-1:0]       edge_waddr, edge_raddr, dist_waddr, dist_raddr;
   logic [EntryW-1:0]      edge_wdata, edge_rdata, dist_wdata, dist_rdata;

   // Helpers.
   logic                   req_fire, req_inrange, out_free;
   logic [IdxW-1:0]        req_row, req_col, n_last;
   logic                   j_last, k_last, i_last, adv_j, adv_k;
   logic [LENGTH_BITS:0]   sum_wide;
   logic [IdxW+EtW:0]      lim_wide;
   logic                   dij_ok, better;
   logic [LENGTH_BITS-1:0] dij_len;
   logic                   chk_dist_we_ok, chk_update, chk_mirror, chk_relax;
   logic                   rsp_stalled;

   apsp_ram #(.WIDTH(EntryW), .DEPTH(CellCount)) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .re    (edge_re),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   apsp_ram #(.WIDTH(EntryW), .DEPTH(CellCount)) u_dist_ram (
      .clock (clock),
      .we    (dist_we),
      .waddr (dist_waddr),
      .wdata (dist_wdata),
      .re    (dist_re),
      .raddr (dist_raddr),
      .rdata (dist_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_inrange    = (int'(req_chan.data.row) < MAX_VERTICES) &&
                           (int'(req_chan.data.col) < MAX_VERTICES);
   assign req_row        = IdxW'(req_chan.data.row);
   assign req_col        = IdxW'(req_chan.data.col);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign n_last = IdxW'(n_ff - 1'b1);
   assign j_last = (j_ff == n_last);
   assign k_last = (k_ff == n_last);
   assign i_last = (i_ff == n_last);

   assign sum_wide = {1'b0, dik_ff} + {1'b0, dist_rdata[LENGTH_BITS-1:0]};
   assign dij_ok   = dist_rdata[LENGTH_BITS];
   assign dij_len  = dist_rdata[LENGTH_BITS-1:0];
   assign better   = kj_ok_ff && (!dij_ok || (sum_ff < dij_len));
   assign lim_wide = ((int'(et_ff) > int'(n_ff)) ? (IdxW+EtW+1)'(et_ff)
                                                 : (IdxW+EtW+1)'(n_ff))
                     + (IdxW+EtW+1)'(2);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      n_in          = n_ff;
      et_in         = et_ff;
      limit_in      = limit_ff;
      pass_in       = pass_ff;
      changed_in    = changed_ff;
      status_in     = status_ff;
      rd_inrange_in = rd_inrange_ff;
      maxdiff_in    = maxdiff_ff;
      diff_in       = diff_ff;
      dik_in        = dik_ff;
      sum_in        = sum_ff;
      kj_ok_in      = kj_ok_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      edge_we       = 1'b0;
      edge_waddr    = cell_addr(req_row, req_col);
      edge_wdata    = {req_chan.data.edge_present,
                       LENGTH_BITS'(req_chan.data.edge_length)};
      edge_re       = 1'b0;
      edge_raddr    = cell_addr(i_ff, j_ff);
      dist_we       = 1'b0;
      dist_waddr    = cell_addr(i_ff, j_ff);
      dist_wdata    = {1'b1, sum_ff};
      dist_re       = 1'b0;
      dist_raddr    = cell_addr(req_row, req_col);
      adv_j         = 1'b0;
      adv_k         = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep every edge entry to "no edge" once after reset.
            edge_we    = 1'b1;
            edge_waddr = clr_ff;
            edge_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == AddrW'(CellCount - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.data.command)
                  apsp_pkg::CMD_WRITE: begin
                     edge_we = req_inrange;
                  end
                  apsp_pkg::CMD_RUN: begin
                     if (vc_ff == '0) begin
                        n_in = (IdxW+1)'(1);
                     end else if (int'(vc_ff) > MAX_VERTICES) begin
                        n_in = (IdxW+1)'(MAX_VERTICES);
                     end else begin
                        n_in = (IdxW+1)'(vc_ff);
                     end
                     i_in     = '0;
                     j_in     = '0;
                     et_in    = '0;
                     state_in = S_INIT_RD;
                  end
                  apsp_pkg::CMD_READ: begin
                     dist_re       = 1'b1;
                     rd_inrange_in = req_inrange;
                     state_in      = S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in                 = '0;
               rsp_data_in.result_kind     = apsp_pkg::KIND_READ;
               rsp_data_in.distance_finite = rd_inrange_ff && dij_ok;
               if (rd_inrange_ff && dij_ok) begin
                  rsp_data_in.distance = (dij_len > LENGTH_BITS'(32'hFFFF_FFFF)) ?
                                         32'hFFFF_FFFF : 32'(dij_len);
               end
               state_in = S_IDLE;
            end
         end
         S_INIT_RD: begin
            edge_re  = 1'b1;
            state_in = S_INIT_WR;
         end
         S_INIT_WR: begin
            dist_we = 1'b1;
            if (i_ff == j_ff) begin
               dist_wdata = {1'b1, {LENGTH_BITS{1'b0}}};
            end else if (edge_rdata[LENGTH_BITS]) begin
               dist_wdata = edge_rdata;
               et_in      = et_ff + 1'b1;
            end else begin
               dist_wdata = '0;
            end
            state_in = S_INIT_RD;
            if (!j_last) begin
               j_in = j_ff + 1'b1;
            end else if (!i_last) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end else begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            limit_in   = (int'(lim_wide) > apsp_pkg::PASS_CAP) ?
                         10'(apsp_pkg::PASS_CAP) : 10'(lim_wide);
            pass_in    = '0;
            i_in       = '0;
            k_in       = '0;
            changed_in = 1'b0;
            maxdiff_in = '0;
            state_in   = S_K_RD;
         end
         S_K_RD: begin
            if (k_ff == i_ff) begin
               adv_k = 1'b1;
            end else begin
               edge_re    = 1'b1;
               edge_raddr = cell_addr(i_ff, k_ff);
               dist_re    = 1'b1;
               dist_raddr = cell_addr(i_ff, k_ff);
               state_in   = S_K_CHK;
            end
         end
         S_K_CHK: begin
            if (edge_rdata[LENGTH_BITS] && dist_rdata[LENGTH_BITS]) begin
               dik_in   = dij_len;
               j_in     = '0;
               state_in = S_J_RD1;
            end else begin
               adv_k = 1'b1;
            end
         end
         S_J_RD1: begin
            if (j_ff == i_ff || j_ff == k_ff) begin
               adv_j = 1'b1;
            end else begin
               dist_re    = 1'b1;
               dist_raddr = cell_addr(k_ff, j_ff);
               state_in   = S_J_RD2;
            end
         end
         S_J_RD2: begin
            // D(k,j) is on the read port; form the saturated path sum.
            kj_ok_in   = dist_rdata[LENGTH_BITS];
            sum_in     = sum_wide[LENGTH_BITS] ? '1 : sum_wide[LENGTH_BITS-1:0];
            dist_re    = 1'b1;
            dist_raddr = cell_addr(i_ff, j_ff);
            state_in   = S_J_CMP;
         end
         S_J_CMP: begin
            if (better) begin
               dist_we    = 1'b1;
               changed_in = 1'b1;
               diff_in    = dij_ok ? (dij_len - sum_ff) : sum_ff;
               state_in   = S_J_WR2;
            end else begin
               adv_j = 1'b1;
            end
         end
         S_J_WR2: begin
            dist_we    = 1'b1;
            dist_waddr = cell_addr(j_ff, i_ff);
            if (diff_ff > maxdiff_ff) begin
               maxdiff_in = diff_ff;
            end
            adv_j = 1'b1;
         end
         S_PASS_END: begin
            state_in = S_EMIT_RUN;
            if (!changed_ff) begin
               status_in = apsp_pkg::STATUS_CONVERGED;
            end else if (maxdiff_ff < tol_ff) begin
               status_in = apsp_pkg::STATUS_TOLERANCE;
            end else if (pass_ff + 1'b1 == limit_ff) begin
               status_in = apsp_pkg::STATUS_LIMIT;
               pass_in   = limit_ff;
            end else begin
               pass_in    = pass_ff + 1'b1;
               i_in       = '0;
               k_in       = '0;
               changed_in = 1'b0;
               maxdiff_in = '0;
               state_in   = S_K_RD;
            end
         end
         S_EMIT_RUN: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in            = '0;
               rsp_data_in.result_kind = apsp_pkg::KIND_RUN;
               rsp_data_in.run_status = status_ff;
               rsp_data_in.pass_count = pass_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Loop advance: j inside k inside i.
      if (adv_j) begin
         if (!j_last) begin
            j_in     = j_ff + 1'b1;
            state_in = S_J_RD1;
         end else begin
            adv_k = 1'b1;
         end
      end
      if (adv_k) begin
         if (!k_last) begin
            k_in     = k_ff + 1'b1;
            state_in = S_K_RD;
         end else if (!i_last) begin
            i_in     = i_ff + 1'b1;
            k_in     = '0;
            state_in = S_K_RD;
         end else begin
            state_in = S_PASS_END;
         end
      end
   end

   // Configuration registers.
   always_comb begin
      vc_in  = vc_ff;
      tol_in = tol_ff;
      if (csr_we) begin
         unique case (csr_index)
            apsp_pkg::CSR_VERTEX_COUNT: vc_in  = csr_wdata[5:0];
            apsp_pkg::CSR_TOLERANCE:    tol_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         vc_ff        <= 6'd32;
         tol_ff       <= '0;
         et_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         vc_ff        <= vc_in;
         tol_ff       <= tol_in;
         et_ff        <= et_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      n_ff          <= n_in;
      limit_ff      <= limit_in;
      pass_ff       <= pass_in;
      changed_ff    <= changed_in;
      status_ff     <= status_in;
      rd_inrange_ff <= rd_inrange_in;
      maxdiff_ff    <= maxdiff_in;
      diff_ff       <= diff_in;
      dik_ff        <= dik_in;
      sum_ff        <= sum_in;
      kj_ok_ff      <= kj_ok_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   assign chk_dist_we_ok = (state_ff == S_INIT_WR) || (state_ff == S_J_CMP) ||
                           (state_ff == S_J_WR2);
   assign chk_update     = (state_ff == S_J_CMP) && better;
   assign chk_mirror     = (state_ff == S_J_WR2);
   assign chk_relax      = (state_ff == S_K_RD);
   assign rsp_stalled    = rsp_valid_ff && !rsp_chan.ready;

   // The distance store is written only during setup or a relaxation update.
   `APSP_ASSERT_NOW(a_dist_we_state, clock, reset, dist_we, chk_dist_we_ok, "stray dist write")
   // The mirrored write always follows the primary write of an update.
   `APSP_ASSERT_NEXT(a_mirror_order, clock, reset, chk_update, chk_mirror, "mirror skipped")
   // Relaxation never runs at or past the pass limit.
   `APSP_ASSERT_NOW(a_pass_bound, clock, reset, chk_relax, pass_ff < limit_ff, "pass overrun")
   // A pending response stays valid and unchanged until it is taken.
   `APSP_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_stalled, rsp_valid_ff, "response dropped")
   `APSP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stalled, $stable(rsp_data_ff), "rsp changed")
endmodule

// ===== sim/tb_all_pairs_shortest_path_relax.sv =====
// ----------------------------------------------------------------------------
// tb_all_pairs_shortest_path_relax
// Self-checking bench for the all-pairs shortest path relaxation block.
// Edge loads, runs and distance reads go in with random idle gaps on both
// channels. A scoreboard keeps its own edge and distance matrices and checks
// each response, field by field, against the answer it works out.
// ----------------------------------------------------------------------------
module tb_all_pairs_shortest_path_relax;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VERTS = 32;
   localparam logic [32:0] LEN_LIMIT = 33'h0_FFFF_FFFF;
   // The one command code that the block ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Scoreboard: a private copy of the edge and distance stores, plus the
   // queue of responses that accepted requests still owe.
   class path_scoreboard;
      bit                    edge_ok [VERTS][VERTS];
      logic [31:0]           edge_len [VERTS][VERTS];
      bit                    dist_ok [VERTS][VERTS];
      logic [31:0]           dist_len [VERTS][VERTS];
      logic [5:0]            vcount;
      logic [31:0]           tol;
      apsp_pkg::rsp_type     owed[$];
      int                    mismatches;

      function new();
         foreach (edge_ok[i, j]) begin
            edge_ok[i][j] = 0;
            edge_len[i][j] = '0;
            dist_ok[i][j] = 0;
            dist_len[i][j] = '0;
         end
         vcount = 6'd32;
         tol = '0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [apsp_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] val);
         if (idx == apsp_pkg::CSR_VERTEX_COUNT) vcount = val[5:0];
         else tol = val;
      endfunction

      // Rebuilds the distance matrix and relaxes it pass after pass, in place,
      // exactly in the order the hardware walks it.
      function void relax_all(output logic [1:0] status, output logic [9:0] passes);
         int n, edges, limit;
         bit changed;
         logic [32:0] sum, gain, best_gain;
         n = (vcount == 0) ? 1 : (vcount > VERTS) ? VERTS : vcount;
         edges = 0;
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
               if (i == j) begin
                  dist_ok[i][j] = 1;
                  dist_len[i][j] = '0;
               end else begin
                  dist_ok[i][j] = edge_ok[i][j];
                  dist_len[i][j] = edge_ok[i][j] ? edge_len[i][j] : '0;
                  if (edge_ok[i][j]) edges++;
               end
            end
         limit = 2 + ((edges > n) ? edges : n);
         if (limit > apsp_pkg::PASS_CAP) limit = apsp_pkg::PASS_CAP;
         for (int p = 0; p < limit; p++) begin
            changed = 0;
            best_gain = '0;
            for (int i = 0; i < n; i++)
               for (int k = 0; k < n; k++) begin
                  if (k == i || !edge_ok[i][k] || !dist_ok[i][k]) continue;
                  for (int j = 0; j < n; j++) begin
                     if (j == i || j == k || !dist_ok[k][j]) continue;
                     sum = {1'b0, dist_len[i][k]} + {1'b0, dist_len[k][j]};
                     if (sum > LEN_LIMIT) sum = LEN_LIMIT;
                     if (dist_ok[i][j] && !(sum < {1'b0, dist_len[i][j]})) continue;
                     gain = dist_ok[i][j] ? {1'b0, dist_len[i][j]} - sum : sum;
                     dist_ok[i][j] = 1;
                     dist_len[i][j] = sum[31:0];
                     dist_ok[j][i] = 1;
                     dist_len[j][i] = sum[31:0];
                     changed = 1;
                     if (gain > best_gain) best_gain = gain;
                  end
               end
            if (!changed) begin
               status = apsp_pkg::STATUS_CONVERGED;
               passes = p[9:0];
               return;
            end
            if (best_gain < {1'b0, tol}) begin
               status = apsp_pkg::STATUS_TOLERANCE;
               passes = p[9:0];
               return;
            end
         end
         status = apsp_pkg::STATUS_LIMIT;
         passes = limit[9:0];
      endfunction

      function void note_request(apsp_pkg::req_type r);
         apsp_pkg::rsp_type x;
         x = '0;
         case (r.command)
            apsp_pkg::CMD_WRITE: begin
               edge_ok[r.row][r.col] = r.edge_present;
               edge_len[r.row][r.col] = r.edge_length;
            end
            apsp_pkg::CMD_RUN: begin
               x.result_kind = apsp_pkg::KIND_RUN;
               relax_all(x.run_status, x.pass_count);
               owed.push_back(x);
            end
            apsp_pkg::CMD_READ: begin
               x.result_kind = apsp_pkg::KIND_READ;
               x.distance_finite = dist_ok[r.row][r.col];
               x.distance = dist_ok[r.row][r.col] ? dist_len[r.row][r.col] : '0;
               owed.push_back(x);
            end
            default: ;
         endcase
      endfunction

      function void check_response(apsp_pkg::rsp_type got);
         apsp_pkg::rsp_type want;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         want = owed.pop_front();
         if (got.result_kind !== want.result_kind || got.distance !== want.distance ||
             got.distance_finite !== want.distance_finite ||
             got.run_status !== want.run_status || got.pass_count !== want.pass_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: kind %0d/%0d dist %h/%h fin %0d/%0d st %0d/%0d pass %0d/%0d",
                        want.result_kind, got.result_kind, want.distance, got.distance,
                        want.distance_finite, got.distance_finite,
                        want.run_status, got.run_status, want.pass_count, got.pass_count);
         end
      endfunction
   endclass

   logic                             clock = 0;
   logic                             reset = 1;
   logic                             csr_we = 0;
   logic [apsp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]                      csr_wdata = '0;

   apsp_req_if req_chan ();
   apsp_rsp_if rsp_chan ();

   path_scoreboard board = new();

   // Shared between the request and response processes, apart from item_count.
   bit quiet = 0;        // no idling for the closing stretch
   bit hold_off = 0;     // ask the receiver for one long stall
   int item_count = 0;

   all_pairs_shortest_path_relax uut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #1 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.data = '0;
      rsp_chan.ready = 0;
   end

   // Every accepted response is checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) board.check_response(rsp_chan.data);
   end

   // Callers must write registers only while the block is idle; this task does not enforce it.
   task automatic write_reg(logic [apsp_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
      board.set_reg(idx, val);
   endtask

   // Wait for every owed response, then idle so a trailing edge write
   // has surely landed before a register changes.
   task automatic drain();
      while (board.owed.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Offers one request and holds it until accepted. Called at a falling edge.
   task automatic send_request(apsp_pkg::req_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid = 0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_chan.valid = 1;
      req_chan.data = r;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(r);
      item_count++;
      @(negedge clock);
      req_chan.valid = 0;
   endtask

   task automatic send_cmd(logic [1:0] cmd, int r, int c, bit present, logic [31:0] len);
      apsp_pkg::req_type q;
      q.command = cmd;
      q.row = r[4:0];
      q.col = c[4:0];
      q.edge_present = present;
      q.edge_length = len;
      send_request(q);
   endtask

   function automatic logic [31:0] pick_length();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom();
         default: return $urandom_range(1, 32'h0003_0000);
      endcase
   endfunction

   // One random phase: new register settings, then a mix of requests that
   // mostly stays inside the active vertices and ends with a run and three reads.
   task automatic random_phase(int count, bit pause_mid);
      int n, span, r, c, sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) n = $urandom_range(0, 1);
      else if (sel == 1) n = 32;
      else if (sel == 2) n = 63;
      else if (sel == 3) n = $urandom_range(8, 16);
      else n = $urandom_range(2, 7);
      write_reg(apsp_pkg::CSR_VERTEX_COUNT, n);
      case ($urandom_range(0, 7))
         0, 1, 2, 3: write_reg(apsp_pkg::CSR_TOLERANCE, 32'h0);
         4, 5: write_reg(apsp_pkg::CSR_TOLERANCE, $urandom_range(0, 32'h0002_0000));
         6: write_reg(apsp_pkg::CSR_TOLERANCE, $urandom());
         default: write_reg(apsp_pkg::CSR_TOLERANCE, 32'hFFFF_FFFF);
      endcase
      span = (n < 1) ? 1 : (n > 8) ? 8 : n;
      for (int t = 0; t < count; t++) begin
         if (pause_mid && t == count / 2)
            while (board.owed.size() != 0) @(negedge clock);
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            if ($urandom_range(0, 6) != 0)
               send_cmd(apsp_pkg::CMD_WRITE, $urandom_range(0, span - 1),
                        $urandom_range(0, span - 1),
                        $urandom_range(0, 3) != 0, pick_length());
            else
               send_cmd(apsp_pkg::CMD_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 4) == 0, $urandom());
         end else if (sel < 90) begin
            if ($urandom_range(0, 3) != 0) begin
               r = $urandom_range(0, span - 1);
               c = $urandom_range(0, span - 1);
            end else begin
               r = $urandom_range(0, 31);
               c = $urandom_range(0, 31);
            end
            send_cmd(apsp_pkg::CMD_READ, r, c, $urandom_range(0, 1), $urandom());
         end else if (sel < 97) begin
            send_cmd(apsp_pkg::CMD_RUN, $urandom_range(0, 31), $urandom_range(0, 31), 0, '0);
         end else begin
            send_cmd(CMD_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31), 1, $urandom());
         end
      end
      send_cmd(apsp_pkg::CMD_RUN, 0, 0, 0, '0);
      for (int t = 0; t < 3; t++)
         send_cmd(apsp_pkg::CMD_READ, $urandom_range(0, span - 1),
                  $urandom_range(0, span - 1), 0, '0);
      drain();
   endtask

   // Response side: random stall bursts, one long stall on request, and a
   // steady ready once the closing stretch begins.
   initial begin
      @(negedge clock);
      while (1) begin
         @(negedge clock);
         if (hold_off) begin
            rsp_chan.ready = 0;
            for (int w = 0; w < 400; w++) @(negedge clock);
            hold_off = 0;
            rsp_chan.ready = 1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready = 0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_chan.ready = 1;
         end else begin
            rsp_chan.ready = 1;
         end
      end
   end

   // Request side.
   initial begin
      repeat (10) @(negedge clock);
      reset = 0;
      write_reg(apsp_pkg::CSR_VERTEX_COUNT, 32);
      write_reg(apsp_pkg::CSR_TOLERANCE, 32'h0);

      // Directed part: length extremes, saturating sums, diagonal entries,
      // the top indices, an absent edge and the unused command. The first run
      // covers the full matrix, so every later read sees initialised cells.
      send_cmd(apsp_pkg::CMD_WRITE, 0, 1, 1, 32'h0);
      send_cmd(apsp_pkg::CMD_WRITE, 1, 2, 1, 32'hFFFF_FFFF);
      send_cmd(apsp_pkg::CMD_WRITE, 2, 3, 1, 32'h0001_8000);
      send_cmd(apsp_pkg::CMD_WRITE, 31, 31, 1, 32'hAAAA_AAAA);
      send_cmd(apsp_pkg::CMD_WRITE, 31, 30, 1, 32'h5555_5555);
      send_cmd(apsp_pkg::CMD_WRITE, 30, 29, 1, 32'hFFFF_FFFF);
      send_cmd(apsp_pkg::CMD_WRITE, 0, 31, 0, 32'hFFFF_FFFF);
      send_cmd(CMD_UNUSED, 31, 31, 1, 32'hFFFF_FFFF);
      send_cmd(apsp_pkg::CMD_RUN, 0, 0, 0, '0);
      send_cmd(apsp_pkg::CMD_READ, 0, 2, 0, '0);
      send_cmd(apsp_pkg::CMD_READ, 3, 0, 0, '0);
      send_cmd(apsp_pkg::CMD_READ, 31, 29, 0, '0);
      send_cmd(apsp_pkg::CMD_READ, 29, 31, 0, '0);
      send_cmd(apsp_pkg::CMD_READ, 7, 7, 0, '0);
      send_cmd(apsp_pkg::CMD_READ, 0, 31, 0, '0);
      drain();
      // A vertex count of zero acts as one vertex; the top value acts as all.
      write_reg(apsp_pkg::CSR_VERTEX_COUNT, 0);
      send_cmd(apsp_pkg::CMD_RUN, 0, 0, 0, '0);
      drain();
      write_reg(apsp_pkg::CSR_VERTEX_COUNT, 63);
      write_reg(apsp_pkg::CSR_TOLERANCE, 32'hFFFF_FFFF);
      send_cmd(apsp_pkg::CMD_RUN, 0, 0, 0, '0);
      send_cmd(apsp_pkg::CMD_READ, 31, 29, 0, '0);
      drain();
      write_reg(apsp_pkg::CSR_VERTEX_COUNT, 4);
      send_cmd(apsp_pkg::CMD_RUN, 0, 0, 0, '0);
      send_cmd(apsp_pkg::CMD_READ, 0, 3, 0, '0);
      drain();

      // Random part. One phase has the receiver stall for a long stretch so
      // the output register fills and the input backs up; another pauses the
      // sender until all owed responses are in.
      for (int ph = 0; item_count < 650; ph++) begin
         if (ph == 2) hold_off = 1;
         if (item_count > 560) quiet = 1;
         random_phase($urandom_range(20, 40), ph == 4);
      end

      while (board.owed.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (board.mismatches == 0) $display("all_pairs_shortest_path_relax test passed");
      else $display("all_pairs_shortest_path_relax test failed");
      $finish;
   end

   initial begin
      #8ms;
      $display("all_pairs_shortest_path_relax test failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/apsp_pkg.sv
sv/apsp_req_if.sv
sv/apsp_rsp_if.sv
sv/apsp_ram.sv
sv/all_pairs_shortest_path_relax.sv
sim/tb_all_pairs_shortest_path_relax.sv
